>>> design/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg : shared types and constants of the cartridge bank mapper
// Request/response words, request codes, register addresses, reset banks.
// ----------------------------------------------------------------------------
package cbm_pkg;

   // 8K program banks on the cartridge
   localparam int PRG_BANKS_8K = 32;

   // reset banks of the two upper program slots
   localparam logic [8:0] PRG_RST_SLOT2 =
      (PRG_BANKS_8K >= 32) ? 9'd30 : 9'(PRG_BANKS_8K - 2);
   localparam logic [8:0] PRG_RST_SLOT3 =
      (PRG_BANKS_8K >= 32) ? 9'd31 : 9'(PRG_BANKS_8K - 1);

   localparam logic [15:0] IRQ_STEP = 16'd113;

   // high-range register addresses
   localparam logic [15:0] ADDR_CTL_A    = 16'h8000;
   localparam logic [15:0] ADDR_CTL_B    = 16'hB000;
   localparam logic [15:0] ADDR_CTL_C    = 16'hB0FF;
   localparam logic [15:0] ADDR_CTL_D    = 16'hB1FF;
   localparam logic [15:0] ADDR_MIRROR   = 16'h8100;
   localparam logic [15:0] ADDR_CNT_LO   = 16'h8200;
   localparam logic [15:0] ADDR_CNT_HI   = 16'h8201;
   localparam logic [15:0] ADDR_PRG_LO   = 16'h8300;
   localparam logic [15:0] ADDR_PRG_HI   = 16'h8302;
   localparam logic [15:0] ADDR_CHR_LO   = 16'h8310;
   localparam logic [15:0] ADDR_CHR_HI   = 16'h8317;
   localparam logic [15:0] ADDR_PAIR     = 16'h8318;

   // low-range addresses
   localparam logic [15:0] ADDR_RB_LO    = 16'h5101;
   localparam logic [15:0] ADDR_RB_HI    = 16'h5103;
   localparam logic [15:0] RB_READ_MASK  = 16'h5100;

   localparam logic [1:0] MIRROR_SIDE  = 2'd0;
   localparam logic [1:0] MIRROR_HORZ  = 2'd1;
   localparam logic [1:0] MIRROR_PAGE0 = 2'd2;
   localparam logic [1:0] MIRROR_PAGE1 = 2'd3;

   typedef enum logic [2:0] {
      REQ_HIGH_WR = 3'd0,
      REQ_LOW_WR  = 3'd1,
      REQ_LOW_RD  = 3'd2,
      REQ_TICK    = 3'd3,
      REQ_PRG_Q   = 3'd4,
      REQ_CHR_Q   = 3'd5,
      REQ_NT_Q    = 3'd6
   } req_code_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [15:0] addr;
      logic [7:0]  data;
   } req_word_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [9:0] mapped_bank;
      logic       irq_pulse;
   } rsp_word_type;

   // pattern table memory access
   typedef struct packed {
      logic       wr_en;
      logic       rd_en;
      logic [2:0] idx;
      logic [9:0] value;
   } chr_access_type;

endpackage

>>> design/cartridge_bank_mapper_with_scanline_irq.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_with_scanline_irq : bank mapper with scanline IRQ
// Response: registered; valid in the cycle after a request word is accepted.
// Throughput: one word per cycle while the response side does not stall; the
//   registered read of the pattern bank memory shares the response stage.
// Reset: synchronous; latches, counter and mirroring clear, program slots
//   take 0, 1 and the last two banks, pattern slots read as 0 to 7 at once.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_with_scanline_irq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  cbm_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output cbm_pkg::rsp_word_type rsp_word
);

   // A new word enters whenever the response register is empty or being
   // drained in the same cycle; nothing enters while reset is high.
   logic                    accept;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    sel_chr;
   logic [9:0]              chr_bank;
   cbm_pkg::chr_access_type chr_acc;
   cbm_pkg::rsp_word_type   reg_rsp;

   assign req_stall = reset | (rsp_valid_ff & rsp_stall);
   assign accept    = req_valid & ~req_stall;

   // Register file: executes writes, ticks and register-side queries, and
   // issues pattern memory reads/writes.
   cbm_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req_word),
      .chr_acc (chr_acc),
      .rsp     (reg_rsp),
      .sel_chr (sel_chr)
   );

   // Pattern bank memory; its read register doubles as the response stage.
   cbm_chr_ram u_chr_ram (
      .clock (clock),
      .reset (reset),
      .acc   (chr_acc),
      .bank  (chr_bank)
   );

   // response valid: set on accept, cleared once the word is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_word.read_data    = reg_rsp.read_data;
   assign rsp_word.mapped_bank  = sel_chr ? chr_bank : reg_rsp.mapped_bank;
   assign rsp_word.irq_pulse    = reg_rsp.irq_pulse;

   // ---- checks ----
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("response valid after reset");

   a_accept_resp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted word produced no response");

   a_pulse_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word.irq_pulse) |->
      (rsp_word.read_data == 8'd0 && rsp_word.mapped_bank == 10'd0))
      else $error("irq pulse with other response fields set");

endmodule

>>> design/cbm_chr_ram.sv
// ----------------------------------------------------------------------------
// cbm_chr_ram : pattern bank table
// Eight 1K bank entries in a synchronous memory with a registered read;
// entries never written read as their slot index.
// ----------------------------------------------------------------------------
module cbm_chr_ram (
   input  logic                    clock,
   input  logic                    reset,
   input  cbm_pkg::chr_access_type acc,
   output logic [9:0]              bank
);

   logic [9:0] mem [8];
   logic [7:0] valid_ff, valid_in;
   logic [9:0] rdata_ff;
   logic       rvld_ff;
   logic [2:0] ridx_ff;

   always_comb begin
      valid_in = valid_ff;
      if (acc.wr_en) begin
         valid_in[acc.idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc.wr_en) begin
         mem[acc.idx] <= acc.value;
      end
      if (acc.rd_en) begin
         rdata_ff <= mem[acc.idx];
         rvld_ff  <= valid_ff[acc.idx];
         ridx_ff  <= acc.idx;
      end
   end

   assign bank = rvld_ff ? rdata_ff : {7'd0, ridx_ff};

endmodule

>>> design/cbm_regs.sv
// ----------------------------------------------------------------------------
// cbm_regs : mapper registers and request execution
// Control/readback latches, program slots, mirroring, scanline counter;
// registers the non-pattern result fields and drives the pattern memory.
// ----------------------------------------------------------------------------
module cbm_regs (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  cbm_pkg::req_word_type   req,
   output cbm_pkg::chr_access_type chr_acc,
   output cbm_pkg::rsp_word_type   rsp,
   output logic                    sel_chr
);

   logic [7:0]  ctl_ff, ctl_in;
   logic [7:0]  rb_ff, rb_in;
   logic [15:0] cnt_ff, cnt_in;
   logic        armed_ff, armed_in;
   logic [1:0]  mir_ff, mir_in;
   logic [8:0]  prg_ff [4];
   logic [8:0]  prg_in [4];

   logic [7:0]  rd_ff, rd_in;
   logic [9:0]  bank_ff, bank_in;
   logic        pulse_ff, pulse_in;
   logic        sel_ff, sel_in;

   logic [7:0]  pair_val;
   logic [5:0]  ctl_low;
   logic [1:0]  quad;
   logic        page;

   always_comb begin
      ctl_in   = ctl_ff;
      rb_in    = rb_ff;
      cnt_in   = cnt_ff;
      armed_in = armed_ff;
      mir_in   = mir_ff;
      prg_in   = prg_ff;
      rd_in    = '0;
      bank_in  = '0;
      pulse_in = 1'b0;
      sel_in   = 1'b0;
      chr_acc  = '0;
      pair_val = (ctl_ff & 8'h30) | req.data;
      ctl_low  = req.data[5:0];
      quad     = req.addr[11:10];
      case (mir_ff)
         cbm_pkg::MIRROR_SIDE:  page = quad[0];
         cbm_pkg::MIRROR_HORZ:  page = quad[1];
         cbm_pkg::MIRROR_PAGE0: page = 1'b0;
         default:               page = 1'b1;
      endcase
      chr_acc.idx   = req.addr[12:10];
      chr_acc.value = {ctl_ff[5:4], req.data};

      if (accept) begin
         unique case (cbm_pkg::req_code_type'(req.req_type))
            cbm_pkg::REQ_HIGH_WR: begin
               if (req.addr == cbm_pkg::ADDR_CTL_A || req.addr == cbm_pkg::ADDR_CTL_B ||
                   req.addr == cbm_pkg::ADDR_CTL_C || req.addr == cbm_pkg::ADDR_CTL_D) begin
                  ctl_in    = req.data;
                  prg_in[0] = {2'd0, ctl_low, 1'b0};
                  prg_in[1] = {2'd0, ctl_low, 1'b1};
                  prg_in[2] = {2'd0, req.data[5:4], 4'hF, 1'b0};
                  prg_in[3] = {2'd0, req.data[5:4], 4'hF, 1'b1};
               end else if (req.addr == cbm_pkg::ADDR_MIRROR) begin
                  mir_in = req.data[1:0];
               end else if (req.addr == cbm_pkg::ADDR_CNT_LO) begin
                  cnt_in = {cnt_ff[15:8], req.data};
               end else if (req.addr == cbm_pkg::ADDR_CNT_HI) begin
                  cnt_in   = {req.data, cnt_ff[7:0]};
                  armed_in = (req.data != 8'd0);
               end else if (req.addr >= cbm_pkg::ADDR_PRG_LO &&
                            req.addr <= cbm_pkg::ADDR_PRG_HI) begin
                  prg_in[req.addr[1:0]] = {1'b0, req.data};
               end else if (req.addr >= cbm_pkg::ADDR_CHR_LO &&
                            req.addr <= cbm_pkg::ADDR_CHR_HI) begin
                  chr_acc.wr_en = 1'b1;
                  chr_acc.idx   = req.addr[2:0];
               end else if (req.addr == cbm_pkg::ADDR_PAIR) begin
                  prg_in[0] = {pair_val, 1'b0};
                  prg_in[1] = {pair_val, 1'b1};
               end
            end
            cbm_pkg::REQ_LOW_WR: begin
               if (req.addr >= cbm_pkg::ADDR_RB_LO && req.addr <= cbm_pkg::ADDR_RB_HI) begin
                  rb_in = req.data;
               end
            end
            cbm_pkg::REQ_LOW_RD: begin
               rd_in = ((req.addr & cbm_pkg::RB_READ_MASK) == cbm_pkg::RB_READ_MASK) ?
                       rb_ff : req.addr[15:8];
            end
            cbm_pkg::REQ_TICK: begin
               if (armed_ff) begin
                  if (cnt_ff <= cbm_pkg::IRQ_STEP) begin
                     pulse_in = 1'b1;
                     armed_in = 1'b0;
                  end else begin
                     cnt_in = cnt_ff - cbm_pkg::IRQ_STEP;
                  end
               end
            end
            cbm_pkg::REQ_PRG_Q: begin
               bank_in = {1'b0, prg_ff[req.addr[14:13]]};
            end
            cbm_pkg::REQ_CHR_Q: begin
               chr_acc.rd_en = 1'b1;
               sel_in        = 1'b1;
            end
            cbm_pkg::REQ_NT_Q: begin
               bank_in = {9'd0, page};
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff    <= '0;
         rb_ff     <= '0;
         cnt_ff    <= '0;
         armed_ff  <= 1'b0;
         mir_ff    <= cbm_pkg::MIRROR_SIDE;
         prg_ff[0] <= 9'd0;
         prg_ff[1] <= 9'd1;
         prg_ff[2] <= cbm_pkg::PRG_RST_SLOT2;
         prg_ff[3] <= cbm_pkg::PRG_RST_SLOT3;
      end else begin
         ctl_ff   <= ctl_in;
         rb_ff    <= rb_in;
         cnt_ff   <= cnt_in;
         armed_ff <= armed_in;
         mir_ff   <= mir_in;
         prg_ff   <= prg_in;
      end
   end

   // result fields, loaded with each accepted word
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff    <= rd_in;
         bank_ff  <= bank_in;
         pulse_ff <= pulse_in;
         sel_ff   <= sel_in;
      end
   end

   assign rsp.read_data   = rd_ff;
   assign rsp.mapped_bank = bank_ff;
   assign rsp.irq_pulse   = pulse_ff;
   assign sel_chr         = sel_ff;

endmodule

>>> bench/tb_cartridge_bank_mapper_with_scanline_irq.sv
// ----------------------------------------------------------------------------
// tb_cartridge_bank_mapper_with_scanline_irq : bank mapper self-checking bench
// Drives request words (register writes, low-range accesses, scanline ticks,
// bank queries) with random gaps and response stalls. A scoreboard tracks the
// mapper state and checks every response word field by field, in order.
// ----------------------------------------------------------------------------
module tb_cartridge_bank_mapper_with_scanline_irq;
   timeunit 1ns;
   timeprecision 1ps;

   // request code outside the defined set; the mapper must answer with zeros
   localparam logic [2:0] REQ_UNUSED = 3'd7;

   // control latch fields
   localparam logic [7:0] CTL_BANK_MASK    = 8'h3F;
   localparam logic [7:0] CTL_HI_MASK      = 8'h30;
   localparam logic [7:0] FIXED_LOW_NIBBLE = 8'h0F;

   localparam int unsigned RANDOM_WORDS = 1550;
   localparam int unsigned QUIET_LIMIT  = 2000;   // cycles with no handshake
   localparam int unsigned DRAIN_CYCLES = 4;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   cbm_pkg::req_word_type req_word;
   logic                  rsp_valid;
   logic                  rsp_stall;
   cbm_pkg::rsp_word_type rsp_word;

   cartridge_bank_mapper_with_scanline_irq u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // -------------------------------------------------------------------------
   // Scoreboard: shadow copy of the mapper state. Each accepted request word
   // updates it and queues the response word it should produce; each
   // accepted response word is checked against the oldest queued one.
   // -------------------------------------------------------------------------
   class bank_map_scoreboard;
      logic [7:0]            ctl_latch;
      logic [7:0]            readback;
      logic [15:0]           irq_count;
      logic                  irq_armed;
      logic [8:0]            prg_bank [4];
      logic [9:0]            chr_bank [8];
      logic [1:0]            mirror;
      cbm_pkg::rsp_word_type expected_rsp [$];
      int unsigned           mismatches;
      int unsigned           checked;
      int unsigned           irq_pulses;

      function void clear();
         ctl_latch   = '0;
         readback    = '0;
         irq_count   = '0;
         irq_armed   = 1'b0;
         prg_bank[0] = 9'd0;
         prg_bank[1] = 9'd1;
         prg_bank[2] = cbm_pkg::PRG_RST_SLOT2;
         prg_bank[3] = cbm_pkg::PRG_RST_SLOT3;
         for (int i = 0; i < 8; i++) chr_bank[i] = 10'(i);
         mirror      = cbm_pkg::MIRROR_SIDE;
         expected_rsp.delete();
         mismatches  = 0;
         checked     = 0;
         irq_pulses  = 0;
      endfunction

      // a 16K bank fills two neighboring 8K slots
      function void set_prg_pair(int unsigned first, logic [7:0] bank16);
         prg_bank[first]     = {bank16, 1'b0};
         prg_bank[first + 1] = {bank16, 1'b1};
      endfunction

      function void note_request(cbm_pkg::req_word_type w);
         cbm_pkg::rsp_word_type e;
         e = '0;
         case (w.req_type)
            cbm_pkg::REQ_HIGH_WR: begin
               case (w.addr)
                  cbm_pkg::ADDR_CTL_A, cbm_pkg::ADDR_CTL_B,
                  cbm_pkg::ADDR_CTL_C, cbm_pkg::ADDR_CTL_D: begin
                     ctl_latch = w.data;
                     set_prg_pair(0, w.data & CTL_BANK_MASK);
                     set_prg_pair(2, (w.data & CTL_HI_MASK) | FIXED_LOW_NIBBLE);
                  end
                  cbm_pkg::ADDR_MIRROR: mirror = w.data[1:0];
                  cbm_pkg::ADDR_CNT_LO: irq_count[7:0] = w.data;
                  cbm_pkg::ADDR_CNT_HI: begin
                     irq_count[15:8] = w.data;
                     irq_armed       = (w.data != 8'd0);
                  end
                  cbm_pkg::ADDR_PAIR: set_prg_pair(0, (ctl_latch & CTL_HI_MASK) | w.data);
                  default: begin
                     if (w.addr >= cbm_pkg::ADDR_PRG_LO && w.addr <= cbm_pkg::ADDR_PRG_HI)
                        prg_bank[w.addr[1:0]] = {1'b0, w.data};
                     else if (w.addr >= cbm_pkg::ADDR_CHR_LO &&
                              w.addr <= cbm_pkg::ADDR_CHR_HI)
                        chr_bank[w.addr[2:0]] = {ctl_latch[5:4], w.data};
                  end
               endcase
            end
            cbm_pkg::REQ_LOW_WR: begin
               if (w.addr >= cbm_pkg::ADDR_RB_LO && w.addr <= cbm_pkg::ADDR_RB_HI)
                  readback = w.data;
            end
            cbm_pkg::REQ_LOW_RD: begin
               // readback latch when the mask bits are all set, else open bus
               e.read_data = ((w.addr & cbm_pkg::RB_READ_MASK) == cbm_pkg::RB_READ_MASK) ?
                             readback : w.addr[15:8];
            end
            cbm_pkg::REQ_TICK: begin
               if (irq_armed) begin
                  if (irq_count <= cbm_pkg::IRQ_STEP) begin
                     e.irq_pulse = 1'b1;
                     irq_armed   = 1'b0;
                     irq_pulses++;
                  end else begin
                     irq_count = irq_count - cbm_pkg::IRQ_STEP;
                  end
               end
            end
            cbm_pkg::REQ_PRG_Q: e.mapped_bank = {1'b0, prg_bank[w.addr[14:13]]};
            cbm_pkg::REQ_CHR_Q: e.mapped_bank = chr_bank[w.addr[12:10]];
            cbm_pkg::REQ_NT_Q: begin
               case (mirror)
                  cbm_pkg::MIRROR_SIDE:  e.mapped_bank = 10'(w.addr[10]);
                  cbm_pkg::MIRROR_HORZ:  e.mapped_bank = 10'(w.addr[11]);
                  cbm_pkg::MIRROR_PAGE0: e.mapped_bank = 10'd0;
                  default:               e.mapped_bank = 10'd1;
               endcase
            end
            default: ;
         endcase
         expected_rsp.push_back(e);
      endfunction

      function void check_response(cbm_pkg::rsp_word_type got);
         cbm_pkg::rsp_word_type e;
         if (expected_rsp.size() == 0) begin
            $display("%0t: response word with none expected: %p", $time, got);
            mismatches++;
            return;
         end
         e = expected_rsp.pop_front();
         checked++;
         if (got.read_data !== e.read_data) begin
            $display("%0t: read_data expected %h actual %h", $time, e.read_data,
                     got.read_data);
            mismatches++;
         end
         if (got.mapped_bank !== e.mapped_bank) begin
            $display("%0t: mapped_bank expected %0d actual %0d", $time, e.mapped_bank,
                     got.mapped_bank);
            mismatches++;
         end
         if (got.irq_pulse !== e.irq_pulse) begin
            $display("%0t: irq_pulse expected %b actual %b", $time, e.irq_pulse,
                     got.irq_pulse);
            mismatches++;
         end
      endfunction
   endclass

   bank_map_scoreboard board;
   int unsigned        words_sent;
   int unsigned        calm_left;
   int unsigned        remap_bursts;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Monitor: values read right after the rising edge are the pre-edge ones.
   // The response side is handled first; as the response is registered, a
   // response at this edge always belongs to an earlier request.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) board.check_response(rsp_word);
         if (req_valid && !req_stall) board.note_request(req_word);
      end
   end

   // Watchdog: ends the run if no word moves on either side for too long.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("%0t: no handshake for %0d cycles, %0d responses still expected", $time,
               QUIET_LIMIT, board.expected_rsp.size());
      $display("end of test: mismatches");
      $finish;
   end

   // Response stall: mostly open, short and occasional long stalls, and
   // calm stretches with no stalls at all.
   initial begin : rsp_backpressure
      int unsigned hold;
      int unsigned calm;
      int unsigned roll;
      hold = 0;
      calm = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         roll = $urandom_range(0, 99);
         if (hold > 0) begin
            hold--;
            rsp_stall <= 1'b1;
         end else if (calm > 0) begin
            calm--;
            rsp_stall <= 1'b0;
         end else if (roll < 3) begin
            calm = $urandom_range(30, 120);
            rsp_stall <= 1'b0;
         end else if (roll < 25) begin
            hold = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else if (roll < 28) begin
            hold = $urandom_range(8, 40);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Idle cycles before the next request word: mostly none or a few,
   // sometimes long, with calm stretches of back-to-back words.
   function automatic int unsigned next_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if (roll < 2) begin
         calm_left = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic cbm_pkg::req_word_type mk(logic [2:0] code, logic [15:0] addr,
                                                logic [7:0] data);
      cbm_pkg::req_word_type w;
      w.req_type = code;
      w.addr     = addr;
      w.data     = data;
      return w;
   endfunction

   // Entered and left at a falling edge. valid is lowered only for a gap,
   // so it never gets two assignments in one step.
   task automatic drive_req(cbm_pkg::req_word_type w, int unsigned gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_word  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      words_sent++;
   endtask

   // A register address: mostly decoded ones, some near misses.
   function automatic logic [15:0] reg_addr();
      case ($urandom_range(0, 7))
         0: case ($urandom_range(0, 3))
               0: return cbm_pkg::ADDR_CTL_A;
               1: return cbm_pkg::ADDR_CTL_B;
               2: return cbm_pkg::ADDR_CTL_C;
               default: return cbm_pkg::ADDR_CTL_D;
            endcase
         1: return cbm_pkg::ADDR_MIRROR;
         2: return cbm_pkg::ADDR_CNT_LO;
         3: return cbm_pkg::ADDR_CNT_HI;
         4: return cbm_pkg::ADDR_PRG_LO + 16'($urandom_range(0, 2));
         5: return cbm_pkg::ADDR_CHR_LO + 16'($urandom_range(0, 7));
         6: return cbm_pkg::ADDR_PAIR;
         default: case ($urandom_range(0, 3))
               0: return cbm_pkg::ADDR_PRG_HI + 16'd1;
               1: return cbm_pkg::ADDR_CHR_LO - 16'd1;
               2: return cbm_pkg::ADDR_PAIR + 16'd1;
               default: return cbm_pkg::ADDR_CTL_A + 16'd1;
            endcase
      endcase
   endfunction

   function automatic cbm_pkg::req_word_type query_word();
      case ($urandom_range(0, 2))
         0: return mk(cbm_pkg::REQ_PRG_Q, 16'($urandom), 8'($urandom));
         1: return mk(cbm_pkg::REQ_CHR_Q, 16'($urandom), 8'($urandom));
         default: return mk(cbm_pkg::REQ_NT_Q, 16'($urandom), 8'($urandom));
      endcase
   endfunction

   // Loose random word covering every request code and all address bits.
   function automatic cbm_pkg::req_word_type rand_word();
      cbm_pkg::req_word_type w;
      int unsigned           pick;
      w    = mk(REQ_UNUSED, 16'($urandom), 8'($urandom));
      pick = $urandom_range(0, 99);
      if (pick < 18) begin
         w.req_type = cbm_pkg::REQ_HIGH_WR;
         if ($urandom_range(0, 9) != 0) w.addr = reg_addr();
      end else if (pick < 28) begin
         w.req_type = cbm_pkg::REQ_LOW_WR;
         if ($urandom_range(0, 9) < 7)
            w.addr = cbm_pkg::ADDR_RB_LO + 16'($urandom_range(0, 2));
      end else if (pick < 38) begin
         w.req_type = cbm_pkg::REQ_LOW_RD;
         if ($urandom_range(0, 1) == 1) w.addr = w.addr | cbm_pkg::RB_READ_MASK;
      end else if (pick < 50) begin
         w.req_type = cbm_pkg::REQ_TICK;
      end else if (pick < 98) begin
         w = query_word();
      end
      return w;
   endfunction

   // Counter reload value for the high byte: mostly small so the interrupt
   // fires within a few ticks; zero disarms, and now and then a large count.
   function automatic logic [7:0] count_high();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return 8'd0;
      if (roll < 80) return 8'($urandom_range(1, 2));
      if (roll < 95) return 8'($urandom);
      return 8'hFF;
   endfunction

   initial begin
      board = new;
      board.clear();
      words_sent   = 0;
      calm_left    = 0;
      remap_bursts = 0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_word     = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed part --------------------------------------------------
      // banks and mirroring as reset leaves them
      drive_req(mk(cbm_pkg::REQ_PRG_Q, 16'hC000, 8'h00), 0);
      drive_req(mk(cbm_pkg::REQ_PRG_Q, 16'hE000, 8'h00), 0);
      drive_req(mk(cbm_pkg::REQ_CHR_Q, 16'h1C00, 8'h00), 0);
      drive_req(mk(cbm_pkg::REQ_NT_Q, 16'h2400, 8'h00), 0);
      // readback latch: cleared, loaded, ignored outside its window, open bus
      drive_req(mk(cbm_pkg::REQ_LOW_RD, 16'hFFFF, 8'hFF), 0);
      drive_req(mk(cbm_pkg::REQ_LOW_WR, cbm_pkg::ADDR_RB_HI, 8'hA5), 0);
      drive_req(mk(cbm_pkg::REQ_LOW_WR, cbm_pkg::ADDR_RB_HI + 16'd1, 8'h3C), 0);
      drive_req(mk(cbm_pkg::REQ_LOW_RD, cbm_pkg::RB_READ_MASK, 8'h00), 0);
      drive_req(mk(cbm_pkg::REQ_LOW_RD, 16'hA0FF, 8'h00), 0);
      // control latch at its top value, pattern and pair writes at the top
      drive_req(mk(cbm_pkg::REQ_HIGH_WR, cbm_pkg::ADDR_CTL_D, 8'hFF), 0);
      drive_req(mk(cbm_pkg::REQ_PRG_Q, 16'h8000, 8'h00), 0);
      drive_req(mk(cbm_pkg::REQ_PRG_Q, 16'hFFFF, 8'h00), 0);
      drive_req(mk(cbm_pkg::REQ_HIGH_WR, cbm_pkg::ADDR_CHR_HI, 8'hFF), 0);
      drive_req(mk(cbm_pkg::REQ_CHR_Q, 16'hFFFF, 8'h00), 0);
      drive_req(mk(cbm_pkg::REQ_HIGH_WR, cbm_pkg::ADDR_PAIR, 8'hFF), 0);
      // query outside the program window decodes by its bits alone
      drive_req(mk(cbm_pkg::REQ_PRG_Q, 16'h0000, 8'h00), 0);
      drive_req(mk(cbm_pkg::REQ_HIGH_WR, cbm_pkg::ADDR_PRG_LO, 8'h00), 0);
      // unlisted high address must leave slot 0 alone
      drive_req(mk(cbm_pkg::REQ_HIGH_WR, cbm_pkg::ADDR_PAIR + 16'd1, 8'hFF), 0);
      drive_req(mk(cbm_pkg::REQ_PRG_Q, 16'h8000, 8'h00), 0);
      // single-page mirroring
      drive_req(mk(cbm_pkg::REQ_HIGH_WR, cbm_pkg::ADDR_MIRROR, 8'hFF), 0);
      drive_req(mk(cbm_pkg::REQ_NT_Q, 16'h0000, 8'h00), 0);
      // count 0x0171: three armed ticks count down, the fourth fires and
      // disarms, the fifth does nothing
      drive_req(mk(cbm_pkg::REQ_HIGH_WR, cbm_pkg::ADDR_CNT_LO, 8'h71), 0);
      drive_req(mk(cbm_pkg::REQ_HIGH_WR, cbm_pkg::ADDR_CNT_HI, 8'h01), 0);
      repeat (5) drive_req(mk(cbm_pkg::REQ_TICK, 16'h0000, 8'h00), 0);
      drive_req(mk(REQ_UNUSED, 16'hFFFF, 8'hFF), 0);

      // ---- random part ----------------------------------------------------
      while (words_sent < RANDOM_WORDS) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               // interrupt setup followed by a run of ticks, queries mixed in
               drive_req(mk(cbm_pkg::REQ_HIGH_WR, cbm_pkg::ADDR_CNT_LO, 8'($urandom)),
                         next_gap());
               drive_req(mk(cbm_pkg::REQ_HIGH_WR, cbm_pkg::ADDR_CNT_HI, count_high()),
                         next_gap());
               repeat ($urandom_range(2, 8)) begin
                  if ($urandom_range(0, 3) == 0) drive_req(query_word(), next_gap());
                  drive_req(mk(cbm_pkg::REQ_TICK, 16'($urandom), 8'($urandom)),
                            next_gap());
               end
            end
            2, 3: begin
               // remap: control latch, a few register writes, then lookups
               remap_bursts++;
               drive_req(mk(cbm_pkg::REQ_HIGH_WR, cbm_pkg::ADDR_CTL_A, 8'($urandom)),
                         next_gap());
               repeat ($urandom_range(1, 4))
                  drive_req(mk(cbm_pkg::REQ_HIGH_WR, reg_addr(), 8'($urandom)),
                            next_gap());
               repeat ($urandom_range(3, 8)) drive_req(query_word(), next_gap());
            end
            default: drive_req(rand_word(), next_gap());
         endcase
      end
      req_valid <= 1'b0;

      // ---- drain ----------------------------------------------------------
      while (board.expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d request words driven, %0d responses checked, %0d remap bursts",
               words_sent, board.checked, remap_bursts);
      $display("%0d scanline interrupts raised", board.irq_pulses);
      if (board.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

>>> files.f
design/cbm_pkg.sv
design/cbm_chr_ram.sv
design/cbm_regs.sv
design/cartridge_bank_mapper_with_scanline_irq.sv
bench/tb_cartridge_bank_mapper_with_scanline_irq.sv
